@@ src/xkrbp_pkg.sv @@
// Package for the keyed XOR record blob parser.
// Holds section and element codes, status codes and sizing constants.
// No dependencies.
package xkrbp_pkg;

	localparam int unsigned KEY_BYTES_DEF = 32;
	localparam int unsigned MAX_BLOB_BYTES_DEF = 1048576;
	localparam int unsigned MAX_LIST_COUNT_DEF = 100000;
	localparam logic [31:0] BLOB_MAGIC = 32'h52615370;

	typedef enum logic [2:0] {
		K_CNT  = 3'd0,
		K_LEN  = 3'd1,
		K_BODY = 3'd2,
		K_FIX  = 3'd3,
		K_IGN  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CORRUPT = 2'd1,
		ST_MAGIC   = 2'd2,
		ST_FORMAT  = 2'd3
	} status_t;

	localparam logic [4:0] SEC_REST = 5'd18;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_KLEN = 3'd4
	} reg_idx_t;

	// One decrypted byte handed from the front part to the back part.
	typedef struct packed {
		logic [7:0] plain;
		logic       last;
		logic       key_zero;
	} item_t;

endpackage

@@ src/xor_keyed_record_blob_parser.sv @@
// Top level of the keyed XOR record blob parser.
// Depends on xkrbp_pkg, xkrbp_front, xkrbp_queue and xkrbp_back.
//
// Usage: the input channel takes one encrypted byte per transfer on
// cipher_byte, with last_byte marking the final byte of a blob. Each byte is
// XORed with the cyclic key held in the APB registers and its place in the
// record layout is tracked. Every input transfer yields exactly one output
// transfer carrying plain_byte, section and element_kind; the output for the
// last byte also carries done_res and status.
// Each byte passes through the front queue and then the output register.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output holds and the
// two-entry queue fills; in_stall rises only when the queue is full. Reset
// clears the queue, the layout state and the key position; the key words reset
// to zero and the key length to one. Key registers are to be written only
// while no blob is in flight; the user must keep to this, the block does not enforce it.
module xor_keyed_record_blob_parser #(
	parameter int unsigned KEY_BYTES = xkrbp_pkg::KEY_BYTES_DEF,
	parameter int unsigned MAX_BLOB_BYTES = xkrbp_pkg::MAX_BLOB_BYTES_DEF,
	parameter int unsigned MAX_LIST_COUNT = xkrbp_pkg::MAX_LIST_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  cipher_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  plain_byte,
	output logic [4:0]  section,
	output logic [2:0]  element_kind,
	output logic [1:0]  status,
	output logic        done_res
);
	import xkrbp_pkg::*;

	logic  take, full, qv, qrd;
	item_t wi, ri;

	assign pready = 1'b1;
	assign in_stall = full;

	xkrbp_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.in_valid, .in_byte(cipher_byte), .in_last(last_byte), .in_take(take),
		.q_full(full), .q_item(wi)
	);

	xkrbp_queue u_queue (
		.clk, .arst_n, .wr(take), .wr_item(wi), .full, .rd_valid(qv),
		.rd_item(ri), .rd(qrd)
	);

	xkrbp_back #(.MAX_BLOB_BYTES(MAX_BLOB_BYTES), .MAX_LIST_COUNT(MAX_LIST_COUNT)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_item(ri), .q_rd(qrd), .out_valid, .out_stall,
		.plain_byte, .section, .element_kind, .status, .done_res
	);

endmodule

@@ src/xkrbp_front.sv @@
// Front part: register file for the key, key position and XOR of each byte.
// Depends on xkrbp_pkg.
module xkrbp_front #(
	parameter int unsigned KEY_BYTES = xkrbp_pkg::KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [5:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output logic                 in_take,
	input  logic                 q_full,
	output xkrbp_pkg::item_t     q_item
);
	import xkrbp_pkg::*;

	localparam int unsigned KPW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic [63:0] key_q [4];
	logic [5:0]  klen_q;
	logic [KPW-1:0] kpos_q;
	logic [5:0]  kl;
	logic [5:0]  pos_eff;
	logic [4:0]  kidx;
	logic [7:0]  kb;
	logic [2:0]  ridx;

	assign ridx = paddr[5:3];
	assign kl = (klen_q > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : klen_q;
	assign pos_eff = (6'(kpos_q) >= kl) ? 6'd0 : 6'(kpos_q);
	assign kidx = pos_eff[4:0];
	assign kb = (kl == 6'd0) ? 8'd0 : key_q[kidx[4:3]][8*kidx[2:0] +: 8];
	assign in_take = in_valid && !q_full;

	always_comb begin
		q_item.plain = in_byte ^ kb;
		q_item.last = in_last;
		q_item.key_zero = (kl == 6'd0);
	end

	always_comb begin
		unique case (ridx)
			REG_KEY0: prdata = key_q[0];
			REG_KEY1: prdata = key_q[1];
			REG_KEY2: prdata = key_q[2];
			REG_KEY3: prdata = key_q[3];
			REG_KLEN: prdata = {58'd0, klen_q};
			default:  prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '{default: 64'd0};
			klen_q <= 6'd1;
			kpos_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (ridx)
					REG_KEY0: key_q[0] <= pwdata;
					REG_KEY1: key_q[1] <= pwdata;
					REG_KEY2: key_q[2] <= pwdata;
					REG_KEY3: key_q[3] <= pwdata;
					REG_KLEN: klen_q <= pwdata[5:0];
					default: ;
				endcase
			end
			if (in_take) begin
				if (in_last)
					kpos_q <= '0;
				else if (kl != 6'd0)
					kpos_q <= (pos_eff + 6'd1 >= kl) ? '0 : KPW'(pos_eff + 6'd1);
			end
		end
	end

endmodule

@@ src/xkrbp_queue.sv @@
// Two-entry queue that parts the front part from the back part.
// Depends on xkrbp_pkg.
module xkrbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  xkrbp_pkg::item_t wr_item,
	output logic             full,
	output logic             rd_valid,
	output xkrbp_pkg::item_t rd_item,
	input  logic             rd
);
	import xkrbp_pkg::*;

	item_t mem_q [2];
	logic  wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !wr)
		else $error("write into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !rd_valid |-> !rd)
		else $error("read from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

@@ src/xkrbp_back.sv @@
// Back part: record layout machine and output register.
// Depends on xkrbp_pkg.
module xkrbp_back #(
	parameter int unsigned MAX_BLOB_BYTES = xkrbp_pkg::MAX_BLOB_BYTES_DEF,
	parameter int unsigned MAX_LIST_COUNT = xkrbp_pkg::MAX_LIST_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  xkrbp_pkg::item_t q_item,
	output logic             q_rd,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       plain_byte,
	output logic [4:0]       section,
	output logic [2:0]       element_kind,
	output logic [1:0]       status,
	output logic             done_res
);
	import xkrbp_pkg::*;

	localparam int unsigned TW = $clog2(MAX_BLOB_BYTES + 2);

	logic [TW-1:0] tot_q;
	logic [4:0]  sec_q;
	kind_t       elem_q;
	logic [31:0] ws_q;
	logic [2:0]  biw_q;
	logic [15:0] sl_q;
	logic [16:0] ol_q, il_q;
	logic [1:0]  pp_q, fmt_q;
	logic        mbad_q, fbad_q, pfail_q;

	logic [4:0]  sec_n;
	kind_t       elem_n;
	logic [31:0] ws_n;
	logic [2:0]  biw_n;
	logic [15:0] sl_n;
	logic [16:0] ol_n, il_n;
	logic [1:0]  pp_n, fmt_n;
	logic        mbad_n, fbad_n, pfail_n;
	logic [TW-1:0] tot_n;
	logic [1:0]  st;
	logic [2:0]  need;
	logic [31:0] v;
	logic        adv;

	assign adv = q_valid && (!out_valid || !out_stall);
	assign q_rd = adv;

	function automatic logic is_str(input logic [4:0] s);
		return s == 5'd4 || s == 5'd5 || s == 5'd6 || s == 5'd11;
	endfunction

	always_comb begin
		logic [4:0] s;
		logic [16:0] olx;
		logic [31:0] vv;
		logic do_outer, do_inner, do_sec, do_str, do_cnt;
		sec_n = sec_q; elem_n = elem_q; ws_n = ws_q; biw_n = biw_q; sl_n = sl_q;
		ol_n = ol_q; il_n = il_q; pp_n = pp_q; fmt_n = fmt_q;
		mbad_n = mbad_q; fbad_n = fbad_q; pfail_n = pfail_q;
		s = sec_q + 5'd1; olx = 17'd0; vv = 32'd0;
		do_outer = 1'b0; do_inner = 1'b0; do_sec = 1'b0; do_str = 1'b0; do_cnt = 1'b0;
		tot_n = (tot_q <= TW'(MAX_BLOB_BYTES)) ? tot_q + TW'(1) : tot_q;
		if (elem_q == K_LEN) need = 3'd2;
		else if (elem_q == K_FIX && sec_q == 5'd3) need = 3'd0;
		else if (elem_q == K_FIX && sec_q == 5'd16) need = 3'd1;
		else need = 3'd4;
		v = {ws_q[23:0], q_item.plain};
		if (sec_q != SEC_REST) begin
			if (elem_q == K_BODY) begin
				if (sl_q > 16'd0) sl_n = sl_q - 16'd1;
				if (sl_q <= 16'd1) do_str = 1'b1;
			end else begin
				ws_n = v;
				biw_n = biw_q + 3'd1;
				if (biw_n == need) begin
					if (elem_q == K_CNT) begin
						do_cnt = 1'b1;
					end else if (elem_q == K_LEN) begin
						sl_n = v[15:0];
						if (v[15:0] == 16'd0) do_str = 1'b1;
						else elem_n = K_BODY;
					end else begin
						priority case (sec_q)
							5'd0: if (v != BLOB_MAGIC) begin
								mbad_n = 1'b1; sec_n = SEC_REST; elem_n = K_IGN;
							end else begin
								sec_n = 5'd1; elem_n = K_FIX; biw_n = 3'd0; ws_n = 32'd0;
							end
							5'd1: if (v < 32'd1 || v > 32'd3) begin
								fbad_n = 1'b1; sec_n = SEC_REST; elem_n = K_IGN;
							end else begin
								fmt_n = v[1:0]; sec_n = 5'd2; elem_n = K_FIX;
								biw_n = 3'd0; ws_n = 32'd0;
							end
							5'd2: begin
								sec_n = 5'd3; elem_n = K_FIX; biw_n = 3'd0; ws_n = 32'd0;
							end
							default: do_sec = 1'b1;
						endcase
					end
				end
			end
		end
		if (do_cnt) begin
			if (v > 32'(MAX_LIST_COUNT)) begin
				pfail_n = 1'b1; sec_n = SEC_REST; elem_n = K_IGN;
			end else if (pp_q == 2'd1) begin
				il_n = v[16:0]; pp_n = 2'd2; do_inner = 1'b1;
			end else begin
				ol_n = v[16:0]; do_outer = 1'b1;
			end
		end
		if (do_str) begin
			if (is_str(sec_q)) do_sec = 1'b1;
			else if (sec_q == 5'd7 || sec_q == 5'd9 || sec_q == 5'd10 || sec_q == 5'd12) begin
				if (ol_n > 17'd0) ol_n = ol_n - 17'd1;
				do_outer = 1'b1;
			end else if (sec_q == 5'd13 || sec_q == 5'd14) begin
				if (pp_q == 2'd0) begin
					pp_n = 2'd1; elem_n = K_CNT; biw_n = 3'd0; ws_n = 32'd0;
				end else if (sec_q == 5'd14 && pp_q == 2'd2) begin
					pp_n = 2'd3; elem_n = K_LEN; biw_n = 3'd0; ws_n = 32'd0;
				end else begin
					pp_n = 2'd2;
					if (il_n > 17'd0) il_n = il_n - 17'd1;
					do_inner = 1'b1;
				end
			end else begin
				if (pp_q == 2'd0) begin
					pp_n = 2'd1; elem_n = K_LEN; biw_n = 3'd0; ws_n = 32'd0;
				end else begin
					pp_n = 2'd0;
					if (ol_n > 17'd0) ol_n = ol_n - 17'd1;
					do_outer = 1'b1;
				end
			end
		end
		if (do_inner) begin
			if (il_n == 17'd0) begin
				if (ol_n > 17'd0) ol_n = ol_n - 17'd1;
				do_outer = 1'b1;
			end else begin
				elem_n = K_LEN; biw_n = 3'd0; ws_n = 32'd0;
			end
		end
		if (do_outer) begin
			if (ol_n == 17'd0) do_sec = 1'b1;
			else begin
				pp_n = 2'd0; elem_n = K_LEN; biw_n = 3'd0; ws_n = 32'd0;
			end
		end
		if (do_sec) begin
			if (s == 5'd13 && fmt_n < 2'd2) s = 5'd16;
			if (s == 5'd16 && fmt_n < 2'd3) s = SEC_REST;
			pp_n = 2'd0;
			if (s >= SEC_REST) begin
				sec_n = SEC_REST; elem_n = K_IGN;
			end else begin
				sec_n = s; biw_n = 3'd0; ws_n = 32'd0;
				if (is_str(s)) elem_n = K_LEN;
				else if (s == 5'd16) elem_n = K_FIX;
				else elem_n = K_CNT;
			end
		end
		if (q_item.key_zero) st = ST_CORRUPT;
		else if (tot_n < TW'(4)) st = ST_CORRUPT;
		else if (tot_n < TW'(8) || tot_n > TW'(MAX_BLOB_BYTES)) st = ST_MAGIC;
		else if (mbad_n) st = ST_MAGIC;
		else if (fbad_n) st = ST_FORMAT;
		else if (pfail_n) st = ST_CORRUPT;
		else if (sec_n != SEC_REST) st = ST_CORRUPT;
		else st = ST_OK;
		olx = ol_n; vv = ws_n;
		ol_n = olx; ws_n = vv;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plain_byte <= q_item.plain;
			section <= sec_q;
			element_kind <= (sec_q == SEC_REST) ? K_IGN : elem_q;
			status <= q_item.last ? st : ST_OK;
			done_res <= q_item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			tot_q <= '0; sec_q <= 5'd0; elem_q <= K_FIX; ws_q <= '0; biw_q <= '0;
			sl_q <= '0; ol_q <= '0; il_q <= '0; pp_q <= '0; fmt_q <= '0;
			mbad_q <= 1'b0; fbad_q <= 1'b0; pfail_q <= 1'b0;
		end else begin
			if (adv) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (adv) begin
				if (q_item.last) begin
					tot_q <= '0; sec_q <= 5'd0; elem_q <= K_FIX; ws_q <= '0; biw_q <= '0;
					sl_q <= '0; ol_q <= '0; il_q <= '0; pp_q <= '0; fmt_q <= '0;
					mbad_q <= 1'b0; fbad_q <= 1'b0; pfail_q <= 1'b0;
				end else begin
					tot_q <= tot_n; sec_q <= sec_n; elem_q <= elem_n; ws_q <= ws_n;
					biw_q <= biw_n; sl_q <= sl_n; ol_q <= ol_n; il_q <= il_n;
					pp_q <= pp_n; fmt_q <= fmt_n; mbad_q <= mbad_n; fbad_q <= fbad_n;
					pfail_q <= pfail_n;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (sec_q == SEC_REST) |-> elem_q == K_IGN)
		else $error("trailing section with active element");
	assert property (@(posedge clk) disable iff (!arst_n) (adv && q_item.last) |=> sec_q == 5'd0)
		else $error("state not cleared after last byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(plain_byte))
		else $error("stalled result changed");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for xor_keyed_record_blob_parser. Depends on xkrbp_pkg.
// Drives encrypted blobs through the input channel and programs the key over APB,
// then checks every output transfer against a built-in prediction or a row table.
`timescale 1ns / 1ps

module tb_top;
	import xkrbp_pkg::*;

	localparam logic [4:0] SEC_MAGIC = 5'd0, SEC_FORMAT = 5'd1, SEC_SCHEMA = 5'd2;
	localparam logic [4:0] SEC_STAMP = 5'd3, SEC_VERSION = 5'd4, SEC_VARIANT = 5'd5;
	localparam logic [4:0] SEC_APPID = 5'd6, SEC_SIGNERS = 5'd7, SEC_ENTRIES = 5'd8;
	localparam logic [4:0] SEC_IGNORED = 5'd9, SEC_PREFIX = 5'd10, SEC_SRCDIR = 5'd11;
	localparam logic [4:0] SEC_INSTALL = 5'd12, SEC_ABI_INV = 5'd13, SEC_ABI_HASH = 5'd14;
	localparam logic [4:0] SEC_ABI_TEXT = 5'd15, SEC_FLAG = 5'd16, SEC_BUNDLE = 5'd17;

	typedef struct {
		logic [7:0] plain;
		logic [4:0] sec;
		kind_t      kind;
		status_t    st;
		logic       done;
	} byte_res_t;

	typedef struct {
		logic [7:0] cb;
		logic       last;
		logic       typed;
		logic [4:0] sec;
		kind_t      kind;
		status_t    st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  cipher_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  plain_byte;
	logic [4:0]  section;
	logic [2:0]  element_kind;
	logic [1:0]  status;
	logic        done_res;

	xor_keyed_record_blob_parser dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("xor_keyed_record_blob_parser verification failed");
		$finish;
	end

	// Key registers and layout state of the predictor.
	logic [63:0] key_reg [4];
	logic [5:0]  klen_reg;
	logic [31:0] p_total, p_kpos, p_shift, p_nbyte, p_strleft, p_outer, p_inner;
	logic [31:0] p_phase, p_fmt;
	logic [4:0]  p_sec;
	kind_t       p_elem;
	logic        p_magbad, p_fmtbad, p_fail;

	byte_res_t   expected_bytes [$];
	logic [7:0]  blob_q [$];
	int          errors = 0;
	int          snd_idle = 0, rcv_idle = 0;
	logic        overcap_on;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic void blob_add(input logic [7:0] b);
		blob_q.insert(blob_q.size(), b);
	endfunction

	function automatic void clear_layout();
		p_total = 0; p_kpos = 0; p_sec = SEC_MAGIC; p_elem = K_FIX; p_shift = 0;
		p_nbyte = 0; p_strleft = 0; p_outer = 0; p_inner = 0; p_phase = 0; p_fmt = 0;
		p_magbad = 0; p_fmtbad = 0; p_fail = 0;
	endfunction

	function automatic void begin_field(input kind_t k);
		p_elem = k; p_nbyte = 0; p_shift = 0;
	endfunction

	function automatic void go_idle();
		p_sec = SEC_REST; p_elem = K_IGN;
	endfunction

	function automatic bit is_string_sec(input logic [4:0] s);
		return s == SEC_VERSION || s == SEC_VARIANT || s == SEC_APPID || s == SEC_SRCDIR;
	endfunction

	function automatic void open_section(input logic [4:0] s_in);
		logic [4:0] s;
		s = s_in;
		if (s == SEC_ABI_INV && p_fmt < 2) s = SEC_FLAG;
		if (s == SEC_FLAG && p_fmt < 3) s = SEC_REST;
		p_phase = 0;
		if (s >= SEC_REST) begin
			go_idle();
		end else begin
			p_sec = s;
			if (is_string_sec(s)) begin_field(K_LEN);
			else if (s == SEC_FLAG) begin_field(K_FIX);
			else begin_field(K_CNT);
		end
	endfunction

	function automatic void advance_outer();
		if (p_outer == 0) open_section(p_sec + 5'd1);
		else begin
			p_phase = 0;
			begin_field(K_LEN);
		end
	endfunction

	function automatic void advance_inner();
		if (p_inner == 0) begin
			if (p_outer > 0) p_outer--;
			advance_outer();
		end else begin
			begin_field(K_LEN);
		end
	endfunction

	function automatic void close_string();
		logic [4:0] s;
		s = p_sec;
		if (is_string_sec(s)) begin
			open_section(s + 5'd1);
		end else if (s == SEC_SIGNERS || s == SEC_IGNORED || s == SEC_PREFIX
				|| s == SEC_INSTALL) begin
			if (p_outer > 0) p_outer--;
			advance_outer();
		end else if (s == SEC_ABI_INV || s == SEC_ABI_HASH) begin
			if (p_phase == 0) begin
				p_phase = 1;
				begin_field(K_CNT);
			end else if (s == SEC_ABI_HASH && p_phase == 2) begin
				p_phase = 3;
				begin_field(K_LEN);
			end else begin
				p_phase = 2;
				if (p_inner > 0) p_inner--;
				advance_inner();
			end
		end else begin
			if (p_phase == 0) begin
				p_phase = 1;
				begin_field(K_LEN);
			end else begin
				p_phase = 0;
				if (p_outer > 0) p_outer--;
				advance_outer();
			end
		end
	endfunction

	function automatic void close_count(input logic [31:0] v);
		if (v > MAX_LIST_COUNT_DEF) begin
			p_fail = 1;
			go_idle();
		end else if (p_phase == 1) begin
			p_inner = v;
			p_phase = 2;
			advance_inner();
		end else begin
			p_outer = v;
			advance_outer();
		end
	endfunction

	function automatic void close_word();
		logic [31:0] v;
		v = p_shift;
		if (p_elem == K_CNT) begin
			close_count(v);
		end else if (p_elem == K_LEN) begin
			p_strleft = v & 32'hFFFF;
			if (p_strleft == 0) close_string();
			else p_elem = K_BODY;
		end else begin
			case (p_sec)
				SEC_MAGIC: begin
					if (v != BLOB_MAGIC) begin
						p_magbad = 1;
						go_idle();
					end else begin
						p_sec = SEC_FORMAT;
						begin_field(K_FIX);
					end
				end
				SEC_FORMAT: begin
					if (v < 1 || v > 3) begin
						p_fmtbad = 1;
						go_idle();
					end else begin
						p_fmt = v;
						p_sec = SEC_SCHEMA;
						begin_field(K_FIX);
					end
				end
				SEC_SCHEMA: begin
					p_sec = SEC_STAMP;
					begin_field(K_FIX);
				end
				default: open_section(p_sec + 5'd1);
			endcase
		end
	endfunction

	function automatic byte_res_t parse_byte(input logic [7:0] cb, input logic last);
		byte_res_t r;
		logic [31:0] kl, need;
		logic [7:0] kb;
		kl = (klen_reg > KEY_BYTES_DEF) ? KEY_BYTES_DEF : klen_reg;
		kb = 8'h00;
		if (kl != 0) begin
			if (p_kpos >= kl) p_kpos = 0;
			kb = 8'(key_reg[p_kpos[4:3]] >> (p_kpos[2:0] * 8));
			p_kpos = (p_kpos + 1 >= kl) ? 0 : p_kpos + 1;
		end
		r.plain = cb ^ kb;
		r.sec = p_sec;
		r.kind = (p_sec == SEC_REST) ? K_IGN : p_elem;
		r.st = ST_OK;
		r.done = last;
		if (p_total <= MAX_BLOB_BYTES_DEF) p_total++;
		if (p_sec != SEC_REST) begin
			if (p_elem == K_BODY) begin
				if (p_strleft > 0) p_strleft--;
				if (p_strleft == 0) close_string();
			end else begin
				if (p_elem == K_LEN) need = 2;
				else if (p_elem == K_FIX && p_sec == SEC_STAMP) need = 8;
				else if (p_elem == K_FIX && p_sec == SEC_FLAG) need = 1;
				else need = 4;
				p_shift = (p_shift << 8) | r.plain;
				p_nbyte++;
				if (p_nbyte >= need) close_word();
			end
		end
		if (last) begin
			if (kl == 0) r.st = ST_CORRUPT;
			else if (p_total < 4) r.st = ST_CORRUPT;
			else if (p_total < 8 || p_total > MAX_BLOB_BYTES_DEF) r.st = ST_MAGIC;
			else if (p_magbad) r.st = ST_MAGIC;
			else if (p_fmtbad) r.st = ST_FORMAT;
			else if (p_fail) r.st = ST_CORRUPT;
			else if (p_sec != SEC_REST) r.st = ST_CORRUPT;
			clear_layout();
		end
		return r;
	endfunction

	task automatic send(input logic [7:0] b, input logic l, input logic typed,
			input byte_res_t tex);
		byte_res_t r;
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		cipher_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = parse_byte(b, l);
		expected_bytes.insert(expected_bytes.size(), typed ? tex : r);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_KLEN) klen_reg = v[5:0];
		else key_reg[idx] = v;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk) begin
		byte_res_t e;
		if (out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report("output transfer with nothing expected");
			end else begin
				e = expected_bytes.pop_front();
				if (plain_byte !== e.plain)
					report($sformatf("plain_byte %h, want %h", plain_byte, e.plain));
				if (section !== e.sec)
					report($sformatf("section %0d, want %0d", section, e.sec));
				if (element_kind !== e.kind)
					report($sformatf("element_kind %0d, want %0d", element_kind, e.kind));
				if (status !== e.st)
					report($sformatf("status %0d, want %0d", status, e.st));
				if (done_res !== e.done)
					report($sformatf("done_res %0d, want %0d", done_res, e.done));
			end
		end
		out_stall <= ($urandom_range(99) < rcv_idle);
	end

	function automatic void put_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) blob_add(w[i*8 +: 8]);
	endfunction

	function automatic void put_string();
		int n;
		n = ($urandom_range(19) == 0) ? $urandom_range(300, 20) : $urandom_range(3);
		blob_add(8'(n >> 8));
		blob_add(8'(n));
		for (int i = 0; i < n; i++) blob_add(8'($urandom));
	endfunction

	function automatic int put_count(input int hi);
		int n;
		if (overcap_on && $urandom_range(29) == 0) begin
			put_word($urandom_range(3) == 0 ? MAX_LIST_COUNT_DEF + 1 : $urandom | 32'h0010_0000);
			overcap_on = 0;
			return 0;
		end
		n = $urandom_range(hi);
		put_word(n);
		return n;
	endfunction

	function automatic void put_list();
		int n;
		n = put_count(2);
		for (int i = 0; i < n; i++) put_string();
	endfunction

	function automatic void put_map();
		int n;
		n = put_count(2);
		for (int i = 0; i < n; i++) begin
			put_string();
			put_string();
		end
	endfunction

	function automatic void build_record();
		int fmt, n, m;
		logic [31:0] magic;
		fmt = $urandom_range(1, 3);
		magic = BLOB_MAGIC;
		if ($urandom_range(19) == 0) magic ^= 32'h1 << $urandom_range(31);
		put_word(magic);
		case ($urandom_range(19))
			0: put_word(0);
			1: put_word($urandom_range(3) == 0 ? 4 : $urandom | 32'h4);
			default: put_word(fmt);
		endcase
		put_word($urandom);
		put_word($urandom);
		put_word($urandom);
		put_string(); put_string(); put_string();
		put_list(); put_map(); put_list(); put_list(); put_string(); put_list();
		if (fmt >= 2) begin
			n = put_count(2);
			for (int i = 0; i < n; i++) begin
				put_string();
				put_list();
			end
			n = put_count(2);
			for (int i = 0; i < n; i++) begin
				put_string();
				m = put_count(2);
				for (int j = 0; j < m; j++) begin
					put_string();
					put_string();
				end
			end
			put_map();
		end
		if (fmt == 3) begin
			blob_add(8'($urandom));
			put_map();
		end
		n = $urandom_range(3);
		for (int i = 0; i < n; i++) blob_add(8'($urandom));
	endfunction

	task automatic send_blob();
		int kl, len;
		byte_res_t none;
		none = '{8'h00, 5'd0, K_CNT, ST_OK, 1'b0};
		blob_q.delete();
		overcap_on = 1;
		if ($urandom_range(99) < 75) begin
			build_record();
			if ($urandom_range(6) == 0) begin
				len = $urandom_range(blob_q.size(), 1);
				while (blob_q.size() > len) void'(blob_q.pop_back());
			end
		end else begin
			len = $urandom_range(12, 1);
			for (int i = 0; i < len; i++) blob_add(8'($urandom));
		end
		kl = (klen_reg > KEY_BYTES_DEF) ? KEY_BYTES_DEF : klen_reg;
		for (int i = 0; i < blob_q.size(); i++) begin
			if (kl != 0) blob_q[i] ^= 8'(key_reg[(i % kl) / 8] >> (((i % kl) % 8) * 8));
			send(blob_q[i], i == blob_q.size() - 1, 1'b0, none);
		end
	endtask

	row_t rows [23] = '{
		'{8'h00, 1'b0, 1'b1, SEC_MAGIC, K_FIX, ST_OK},
		'{8'hFF, 1'b0, 1'b1, SEC_MAGIC, K_FIX, ST_OK},
		'{8'hAA, 1'b1, 1'b1, SEC_MAGIC, K_FIX, ST_CORRUPT},
		'{8'h52, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h61, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h53, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h70, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h01, 1'b1, 1'b1, SEC_FORMAT, K_FIX, ST_MAGIC},
		'{8'h52, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h61, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h53, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h70, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h00, 1'b1, 1'b1, SEC_FORMAT, K_FIX, ST_FORMAT},
		'{8'h12, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h34, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h56, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h78, 1'b0, 1'b0, SEC_MAGIC, K_FIX, ST_OK},
		'{8'h9A, 1'b1, 1'b1, SEC_REST, K_IGN, ST_MAGIC}
	};

	logic [5:0] klen_plan [9] = '{6'd32, 6'd0, 6'd5, 6'd40, 6'd1, 6'd17, 6'd32, 6'd3, 6'd8};

	initial begin
		byte_res_t tex;
		int sent;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		klen_reg = 6'd1;
		clear_layout();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 29;
		rcv_idle = 59;
		foreach (rows[i]) begin
			tex = '{rows[i].cb, rows[i].sec, rows[i].kind, rows[i].st, rows[i].last};
			send(rows[i].cb, rows[i].last, rows[i].typed, tex);
		end

		sent = 0;
		for (int ph = 0; ph < 9; ph++) begin
			snd_idle = (ph < 3) ? 29 : (ph < 6) ? 59 : 0;
			rcv_idle = (ph < 3) ? 59 : (ph < 6) ? 29 : 0;
			drain();
			for (int k = 0; k < 4; k++) begin
				if (ph == 0) apb_write(reg_idx_t'(k), '1);
				else if (ph == 4) apb_write(reg_idx_t'(k), '0);
				else apb_write(reg_idx_t'(k), {$urandom, $urandom});
			end
			apb_write(REG_KLEN, 64'(klen_plan[ph]));
			while (sent < (ph + 1) * 160) begin
				send_blob();
				sent += blob_q.size();
			end
		end

		drain();
		if (errors == 0) begin
			$display("xor_keyed_record_blob_parser verification clean");
		end else begin
			$display("xor_keyed_record_blob_parser verification failed");
		end
		$finish;
	end

endmodule
